FILE: hdl/rse_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_pkg - shared types and constants of the RGB Sobel edge block
// Frame limits, field widths, register indexes, result slots and the
// request record passed from the window stage to the result stage.
// ============================================================================
package rse_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SIZE_W = 13;                 // frame_width / frame_height registers
    localparam int THR_W  = 11;                 // edge_threshold register
    localparam int THR_SQ_W = 2 * THR_W;
    localparam int PIX_W  = 8;
    localparam int LINE_W = 2 * PIX_W;          // older row in upper byte, newer row in lower

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
    localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(200);

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    // gray = (r*19595 + g*38470 + b*7471) >> 16
    localparam int GRAY_SUM_W = 24;
    localparam logic [15:0] COEF_RED   = 16'd19595;
    localparam logic [15:0] COEF_GREEN = 16'd38470;
    localparam logic [15:0] COEF_BLUE  = 16'd7471;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2,
        REG_UNUSED         = 2'd3
    } cfg_index_t;

    // Result slots of one pixel, in delivery order.
    // Bit 0 set: result for the row-end column. Bit 1 set: result for the last row.
    typedef enum logic [1:0] {
        SLOT_PREV_ROW      = 2'd0,
        SLOT_PREV_ROW_END  = 2'd1,
        SLOT_LAST_ROW      = 2'd2,
        SLOT_LAST_ROW_END  = 2'd3
    } slot_t;

    localparam int NUM_SLOTS = 4;

    // One gray column of the 3x3 neighborhood, index 0 is the top row.
    typedef logic [2:0][PIX_W-1:0] col_t;

    typedef struct packed {
        col_t                  left_col;
        col_t                  mid_col;
        col_t                  right_col;
        logic [NUM_SLOTS-1:0]  slot_mask;
        logic [ROW_W-1:0]      row;     // row of the incoming pixel
        logic [COL_W-1:0]      col;     // column of the incoming pixel
    } job_t;

endpackage

FILE: hdl/rgb_sobel_edge_threshold.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_sobel_edge_threshold - streaming 3x3 Sobel edge detector on RGB pixels
// Converts each pixel to gray, keeps two gray rows and a window, and marks
// pixels whose squared gradient reaches the squared threshold.
// ============================================================================
// A result reaches m_tvalid through the input register, the held request and the output register.
// Throughput: one pixel per cycle while the output does not stall; last-row pixels give
//   two results each, a row end two, the last row end four, sent one after another.
// Set by: the single output register, which sends one result per cycle while not stalled.
// Reset (aresetn low, synchronous): clears position, window, pipeline valids and
//   loads 640 x 480, threshold 200. Line stores are not cleared; no clearing pass.
module rgb_sobel_edge_threshold (
    input  logic                            aclk,
    input  logic                            aresetn,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // edge results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // edge_value[7:0], out_row[19:8],
                                                       // out_col[31:20]
    output logic                            m_tlast,   // frame_last
    // configuration
    input  logic                            cfg_we,
    input  logic [rse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rse_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rse_pkg::*;

    logic [SIZE_W-1:0]   width_reg, height_reg;
    logic [THR_SQ_W-1:0] thr_sq_reg;
    logic [THR_W-1:0]    thr_wr;

    logic job_valid, job_ready;
    job_t job;

    // Saturate a size into the range the line stores and counters allow.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v < SIZE_W'(2)) begin
            res = SIZE_W'(2);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    assign thr_wr = cfg_wdata[THR_W-1:0];

    // Hold sizes already saturated and the threshold already squared, so the
    // datapath compares against them directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thr_sq_reg <= THR_SQ_W'(THR_RESET) * THR_SQ_W'(THR_RESET);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: begin
                    width_reg <= clamp_size(cfg_wdata[SIZE_W-1:0], SIZE_W'(MAX_WIDTH));
                end
                REG_FRAME_HEIGHT: begin
                    height_reg <= clamp_size(cfg_wdata[SIZE_W-1:0], SIZE_W'(MAX_HEIGHT));
                end
                REG_EDGE_THRESHOLD: begin
                    thr_sq_reg <= THR_SQ_W'(thr_wr) * THR_SQ_W'(thr_wr);
                end
                default: begin
                    // unassigned index: drop the write
                end
            endcase
        end
    end

    // Intake: position tracking, gray conversion, line stores and window.
    rse_window u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    // Results: up to four per pixel request, sent one per cycle while the output is not stalled.
    rse_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .thr_sq    (thr_sq_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: hdl/rse_line_buf.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_line_buf - two gray line stores in one memory
// One write port and one read port with registered read data.
// ============================================================================
module rse_line_buf (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [rse_pkg::COL_W-1:0]   wr_addr,
    input  logic [rse_pkg::LINE_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [rse_pkg::COL_W-1:0]   rd_addr,
    output logic [rse_pkg::LINE_W-1:0]  rd_data
);
    import rse_pkg::*;

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/rse_window.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_window - pixel intake, gray conversion and 3x3 window
// Tracks the raster position, reads the line stores, forms the gray
// neighborhood and hands one request per pixel to the result stage.
// ============================================================================
module rse_window (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,     // red[7:0], green[15:8], blue[23:16]
    input  logic [rse_pkg::SIZE_W-1:0]  frame_width,
    input  logic [rse_pkg::SIZE_W-1:0]  frame_height,
    output logic                        job_valid,
    input  logic                        job_ready,
    output rse_pkg::job_t               job
);
    import rse_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_col0_reg, s1_last_col_reg, s1_top_row_reg, s1_last_row_reg;

    col_t win_mid_reg, win_left_reg;

    logic              accept, advance;
    logic              col_wrap;
    logic [COL_W-1:0]  c_eff;
    logic [ROW_W-1:0]  r_eff;
    logic [SIZE_W-1:0] row_step, c_inc, r_inc;

    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [PIX_W-1:0]      gray;
    logic [LINE_W-1:0]     line_rd;
    col_t                  cur;

    assign accept   = s_tvalid && s_tready;
    assign advance  = s1_valid_reg && job_ready;
    assign s_tready = !s1_valid_reg || job_ready;

    // Position of this pixel; wrap a counter left beyond a smaller size.
    always_comb begin
        col_wrap = {1'b0, col_reg} >= frame_width;
        c_eff    = col_wrap ? '0 : col_reg;
        row_step = {1'b0, row_reg} + (col_wrap ? SIZE_W'(1) : SIZE_W'(0));
        r_eff    = (row_step >= frame_height) ? '0 : row_step[ROW_W-1:0];
        c_inc    = {1'b0, c_eff} + SIZE_W'(1);
        r_inc    = {1'b0, r_eff} + SIZE_W'(1);
        if (c_inc >= frame_width) begin
            col_next = '0;
            row_next = (r_inc >= frame_height) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_red_reg      <= s_tdata[7:0];
            s1_green_reg    <= s_tdata[15:8];
            s1_blue_reg     <= s_tdata[23:16];
            s1_row_reg      <= r_eff;
            s1_col_reg      <= c_eff;
            s1_col0_reg     <= (c_eff == '0);
            s1_last_col_reg <= (c_inc == frame_width);
            s1_top_row_reg  <= (r_eff == '0);
            s1_last_row_reg <= (r_inc == frame_height);
        end
    end

    rse_line_buf u_line_buf (
        .aclk    (aclk),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data ({cur[1], gray}),
        .rd_en   (accept),
        .rd_addr (c_eff),
        .rd_data (line_rd)
    );

    always_comb begin
        gray_sum = GRAY_SUM_W'(s1_red_reg)   * GRAY_SUM_W'(COEF_RED)
                 + GRAY_SUM_W'(s1_green_reg) * GRAY_SUM_W'(COEF_GREEN)
                 + GRAY_SUM_W'(s1_blue_reg)  * GRAY_SUM_W'(COEF_BLUE);
        gray = gray_sum[GRAY_SUM_W-1 -: PIX_W];
        if (s1_top_row_reg) begin
            cur = {gray, gray, gray};
        end else begin
            cur = {gray, line_rd[PIX_W-1:0], line_rd[LINE_W-1:PIX_W]};
        end
    end

    // Shift the window; a row start fills both stored columns with the border.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_mid_reg  <= '0;
            win_left_reg <= '0;
        end else if (advance) begin
            win_left_reg <= s1_col0_reg ? cur : win_mid_reg;
            win_mid_reg  <= cur;
        end
    end

    always_comb begin
        job.left_col  = win_left_reg;
        job.mid_col   = win_mid_reg;
        job.right_col = cur;
        job.row       = s1_row_reg;
        job.col       = s1_col_reg;
        job.slot_mask = '0;
        job.slot_mask[SLOT_PREV_ROW]     = !s1_top_row_reg && !s1_col0_reg;
        job.slot_mask[SLOT_PREV_ROW_END] = !s1_top_row_reg && s1_last_col_reg;
        job.slot_mask[SLOT_LAST_ROW]     = !s1_top_row_reg && s1_last_row_reg && !s1_col0_reg;
        job.slot_mask[SLOT_LAST_ROW_END] = !s1_top_row_reg && s1_last_row_reg
                                           && s1_last_col_reg;
    end

    assign job_valid = s1_valid_reg;

    a_no_line_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && accept |-> s1_col_reg != c_eff)
        else $error("line store read and write hit the same column");

    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !job_ready |=> s1_valid_reg && $stable(s1_col_reg)
                                       && $stable(s1_row_reg))
        else $error("pending pixel lost while result stage was busy");

    a_position_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> {1'b0, s1_col_reg} < frame_width && {1'b0, s1_row_reg} < frame_height)
        else $error("pixel position outside the frame");

endmodule

FILE: hdl/rse_emit.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_emit - Sobel magnitude test and result sequencing
// Holds one pixel request and sends its results one per cycle, while the
// output is not stalled, through the output register.
// ============================================================================
module rse_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  rse_pkg::job_t                 job,
    input  logic [rse_pkg::THR_SQ_W-1:0]  thr_sq,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // edge_value[7:0], out_row[19:8],
                                                    // out_col[31:20]
    output logic                          m_tlast   // frame_last
);
    import rse_pkg::*;

    job_t                 job_reg;
    logic [NUM_SLOTS-1:0] pend_reg, pend_after, pend_next, sel_onehot;
    slot_t                sel;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_edge_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             out_last_reg;

    logic out_load, take;
    col_t lc, mc, rc;
    logic hit;

    function automatic logic grad_hit(input col_t l, input col_t m, input col_t r,
                                      input logic lower, input logic [THR_SQ_W-1:0] tsq);
        logic [1:0]         ti, mi;
        logic signed [10:0] sx, sy;
        logic [9:0]         ax, ay;
        logic [19:0]        sqx, sqy;
        logic [THR_SQ_W-1:0] mag;
        ti = lower ? 2'd1 : 2'd0;
        mi = lower ? 2'd2 : 2'd1;
        sx = ($signed({3'b000, r[ti]}) - $signed({3'b000, l[ti]}))
           + (($signed({3'b000, r[mi]}) - $signed({3'b000, l[mi]})) <<< 1)
           + ($signed({3'b000, r[2]}) - $signed({3'b000, l[2]}));
        sy = ($signed({3'b000, l[2]}) + ($signed({3'b000, m[2]}) <<< 1)
              + $signed({3'b000, r[2]}))
           - ($signed({3'b000, l[ti]}) + ($signed({3'b000, m[ti]}) <<< 1)
              + $signed({3'b000, r[ti]}));
        ax  = sx[10] ? 10'(-sx) : sx[9:0];
        ay  = sy[10] ? 10'(-sy) : sy[9:0];
        sqx = {10'b0, ax} * {10'b0, ax};
        sqy = {10'b0, ay} * {10'b0, ay};
        mag = THR_SQ_W'(sqx) + THR_SQ_W'(sqy);
        return mag >= tsq;
    endfunction

    // Pick the first pending slot.
    always_comb begin
        priority if (pend_reg[SLOT_PREV_ROW]) begin
            sel = SLOT_PREV_ROW;
        end else if (pend_reg[SLOT_PREV_ROW_END]) begin
            sel = SLOT_PREV_ROW_END;
        end else if (pend_reg[SLOT_LAST_ROW]) begin
            sel = SLOT_LAST_ROW;
        end else begin
            sel = SLOT_LAST_ROW_END;
        end
        sel_onehot      = '0;
        sel_onehot[sel] = 1'b1;
    end

    assign out_load   = (pend_reg != '0) && (!out_valid_reg || m_tready);
    assign pend_after = out_load ? (pend_reg & ~sel_onehot) : pend_reg;
    assign job_ready  = (pend_after == '0);
    assign take       = job_valid && job_ready;
    assign pend_next  = take ? job.slot_mask : pend_after;

    // Row-end slots use the middle and right columns, the right one repeated.
    always_comb begin
        lc  = sel[0] ? job_reg.mid_col   : job_reg.left_col;
        mc  = sel[0] ? job_reg.right_col : job_reg.mid_col;
        rc  = job_reg.right_col;
        hit = grad_hit(lc, mc, rc, sel[1], thr_sq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            job_reg <= job;
        end
        if (out_load) begin
            out_edge_reg <= hit ? EDGE_ON : EDGE_OFF;
            out_row_reg  <= sel[1] ? job_reg.row : job_reg.row - ROW_W'(1);
            out_col_reg  <= sel[0] ? job_reg.col : job_reg.col - COL_W'(1);
            out_last_reg <= (sel == SLOT_LAST_ROW_END);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_col_reg, out_row_reg, out_edge_reg};
    assign m_tlast  = out_last_reg;

    a_pend_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != '0 && !out_load |=> pend_reg == $past(pend_reg))
        else $error("pending results changed while the output was stalled");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("result loaded but not presented");

    a_take_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        take && job.slot_mask != '0 |=> pend_reg != '0)
        else $error("request with results was dropped");

endmodule
